### rtl/pvd_pkg.sv
// Shared types and constants for the prefix varint decoder.
package pvd_pkg;

  localparam logic [7:0] HDR_MASK_1 = 8'h3F;
  localparam logic [7:0] HDR_MASK_2 = 8'h1F;
  localparam logic [7:0] HDR_MASK_3 = 8'h0F;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  bytes_left;
    logic [2:0]  code_length;
    logic [31:0] accumulator;
  } pvd_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
    logic [2:0]  encoded_length;
    logic        truncated;
  } pvd_result_t;

endpackage

### rtl/pvd_step.sv
// Combinational decode of one stream byte against the current code state.
module pvd_step import pvd_pkg::*; (
  input  pvd_state_t  cur,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  output pvd_state_t  nxt,
  output pvd_result_t res
);

  logic [2:0]  ones;
  logic [31:0] shifted;
  logic [2:0]  left_dec;

  always_comb begin
    if (!data_byte[7]) begin
      ones = 3'd0;
    end else if (!data_byte[6]) begin
      ones = 3'd1;
    end else if (!data_byte[5]) begin
      ones = 3'd2;
    end else if (!data_byte[4]) begin
      ones = 3'd3;
    end else begin
      ones = 3'd4;
    end
  end

  assign shifted  = {cur.accumulator[23:0], data_byte};
  assign left_dec = cur.bytes_left - 3'd1;

  always_comb begin
    nxt = '0;
    res = '0;
    if (cur.bytes_left == 3'd0) begin
      // Header byte: leading ones give the count of payload bytes.
      case (ones)
        3'd0: begin
          res.valid          = 1'b1;
          res.value          = {24'd0, data_byte};
          res.encoded_length = 3'd1;
        end
        3'd1: nxt.accumulator = {24'd0, data_byte & HDR_MASK_1};
        3'd2: nxt.accumulator = {24'd0, data_byte & HDR_MASK_2};
        3'd3: nxt.accumulator = {24'd0, data_byte & HDR_MASK_3};
        default: nxt.accumulator = '0;
      endcase
      if (ones != 3'd0) begin
        nxt.bytes_left  = ones;
        nxt.code_length = ones + 3'd1;
        if (stream_end) begin
          nxt                = '0;
          res.valid          = 1'b1;
          res.encoded_length = 3'd1;
          res.truncated      = 1'b1;
        end
      end
    end else begin
      nxt.accumulator = shifted;
      nxt.bytes_left  = left_dec;
      nxt.code_length = cur.code_length;
      if (left_dec == 3'd0) begin
        nxt                = '0;
        res.valid          = 1'b1;
        res.value          = shifted;
        res.encoded_length = cur.code_length;
      end else if (stream_end) begin
        nxt                = '0;
        res.valid          = 1'b1;
        res.encoded_length = cur.code_length - left_dec;
        res.truncated      = 1'b1;
      end
    end
  end

endmodule

### rtl/prefix_varint_decoder_top.sv
// Top level of the prefix varint decoder: input register, decode step, result queue.
//
// The input channel (in_valid/in_ready) carries one stream byte per item,
// with stream_end set on the last byte of a stream. The output channel
// (out_valid/out_ready) carries one decoded result per item: the 32-bit
// value, its encoded length in bytes and a truncated flag. A result is made
// when a code completes, or when the stream ends inside a code, in which
// case value is zero and the length counts the bytes seen of that code.
// Bytes that neither finish a code nor end one inside a code make no result.
//
// An accepted byte lands in the input register, where it is decoded
// against the code state; its result, if any, is written into a
// two-entry result queue once the queue can take it. out_valid is driven
// from the queue count, so a result is offered once it is in the queue.
// The block takes one byte per cycle while the queue can take a result.
// When the receiver stalls, the queue keeps taking results until both
// entries hold data, then the input register holds and in_ready falls.
// Synchronous reset empties the input register and the queue and returns
// the decoder to waiting for a header byte.
module prefix_varint_decoder_top import pvd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [2:0]  encoded_length,
  output logic        truncated
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;

  // Code state.
  pvd_state_t  state;
  pvd_state_t  state_next;
  pvd_result_t step_res;

  // Result queue.
  pvd_result_t queue [QUEUE_DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  logic space;
  logic s1_adv;
  logic push;
  logic pop;

  pvd_step u_step (
    .cur        (state),
    .data_byte  (s1_byte),
    .stream_end (s1_end),
    .nxt        (state_next),
    .res        (step_res)
  );

  // The queue can take a result if an entry is free or one leaves now.
  assign space    = (count != 2'(QUEUE_DEPTH)) || out_ready;
  assign s1_adv   = s1_valid && space;
  assign in_ready = !s1_valid || space;
  assign push     = s1_adv && step_res.valid;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_end  <= stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      queue[wr_ptr] <= step_res;
    end
  end

  assign out_valid      = (count != 2'd0);
  assign value          = queue[rd_ptr].value;
  assign encoded_length = queue[rd_ptr].encoded_length;
  assign truncated      = queue[rd_ptr].truncated;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QUEUE_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == 2'(QUEUE_DEPTH)))
    else $error("result written into a full queue");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    push |=> (state.bytes_left == 3'd0 && state.accumulator == 32'd0))
    else $error("decoder not idle after a result");

  a_bytes_left_range: assert property (@(posedge clk) disable iff (rst)
    state.bytes_left <= 3'd4)
    else $error("bytes left beyond longest code");
`endif

endmodule

### bench/prefix_varint_decoder_top_test.sv
// Self-checking testbench for the prefix varint decoder top level.
`timescale 1ns / 1ps

module prefix_varint_decoder_top_test import pvd_pkg::*;;

  // Tracks the code state of the byte stream independently of the block.
  // For every accepted byte it works out whether a result is due and stores
  // it. Results leaving the block are then matched in order against that
  // store.
  class varint_scoreboard;
    typedef struct {
      logic [31:0] value;
      logic [2:0]  len;
      logic        trunc;
    } decoded_t;

    decoded_t    pending_codes[$];
    int          mismatches = 0;
    logic [2:0]  bytes_left = '0;
    logic [2:0]  code_length = '0;
    logic [31:0] accumulator = '0;

    function void push_code(logic [31:0] v, logic [2:0] l, logic t);
      decoded_t d;
      d.value = v;
      d.len   = l;
      d.trunc = t;
      pending_codes.push_back(d);
      bytes_left  = '0;
      code_length = '0;
      accumulator = '0;
    endfunction

    // Advances the code state by one accepted byte.
    function void note_byte(logic [7:0] b, logic last);
      int ones;
      if (bytes_left == 0) begin
        ones = 0;
        while (ones < 4 && b[7 - ones]) ones++;
        if (ones == 0) begin
          push_code({24'h0, b}, 3'd1, 1'b0);
          return;
        end
        case (ones)
          1: accumulator = {24'h0, b & HDR_MASK_1};
          2: accumulator = {24'h0, b & HDR_MASK_2};
          3: accumulator = {24'h0, b & HDR_MASK_3};
          default: accumulator = '0;
        endcase
        bytes_left  = 3'(ones);
        code_length = 3'(ones + 1);
        // The stream ended right on the header of a longer code.
        if (last) push_code('0, 3'd1, 1'b1);
        return;
      end
      accumulator = {accumulator[23:0], b};
      bytes_left  = bytes_left - 3'd1;
      if (bytes_left == 0)
        push_code(accumulator, code_length, 1'b0);
      else if (last)
        push_code('0, code_length - bytes_left, 1'b1);
    endfunction

    function int pending();
      return pending_codes.size();
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(logic [31:0] v, logic [2:0] l, logic t);
      decoded_t e;
      if (pending_codes.size() == 0) begin
        report($sformatf("unexpected result value=%h len=%0d trunc=%0b", v, l, t));
        return;
      end
      e = pending_codes.pop_front();
      if (v !== e.value || l !== e.len || t !== e.trunc)
        report($sformatf("got value=%h len=%0d trunc=%0b, want value=%h len=%0d trunc=%0b",
                         v, l, t, e.value, e.len, e.trunc));
    endtask

    task final_check();
      if (pending_codes.size() != 0)
        report($sformatf("%0d results never arrived", pending_codes.size()));
    endtask
  endclass

  // Roughly 1350 random bytes follow the directed part.
  localparam int RANDOM_BYTES = 1350;
  // The receiver holds off once for this many cycles to back the block up.
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_AT      = 400;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        stream_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value;
  logic [2:0]  encoded_length;
  logic        truncated;

  varint_scoreboard tracker = new();
  int  bytes_sent = 0;
  int  byte_goal = 1 << 30;
  bit  holding = 1'b0;
  bit  hold_done = 1'b0;

  prefix_varint_decoder_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .stream_end     (stream_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .encoded_length (encoded_length),
    .truncated      (truncated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idling is allowed in two of every three windows of 64 bytes, never while
  // the long hold-off runs, and not at all in the last stretch of the run.
  function automatic bit may_idle();
    return !holding && (bytes_sent < byte_goal - 150) && ((bytes_sent / 64) % 3 != 2);
  endfunction

  // Offers one byte and returns at the edge where it is accepted. Valid stays
  // up between back-to-back bytes and only drops for a random gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_valid   <= 1'b1;
    data_byte  <= b;
    stream_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_byte(b, last);
    bytes_sent++;
    if (may_idle() && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Sends one well-formed code with random content. Now and then the stream
  // is cut inside the code, and sometimes it ends on the code's last byte.
  task automatic send_random_code();
    int         ones;
    int         cut;
    int         k;
    logic [7:0] head;
    logic       last;
    ones = $urandom_range(0, 4);
    head = 8'($urandom);
    case (ones)
      0: head[7]   = 1'b0;
      1: head[7:6] = 2'b10;
      2: head[7:5] = 3'b110;
      3: head[7:4] = 4'b1110;
      default: head[7:4] = 4'b1111;
    endcase
    cut = ones + 1;
    if (ones > 0 && $urandom_range(0, 7) == 0) cut = $urandom_range(0, ones - 1);
    for (k = 0; k <= ones; k++) begin
      last = (k == cut) || (k == ones && $urandom_range(0, 5) == 0);
      send_byte((k == 0) ? head : 8'($urandom), last);
      if (k == cut) break;
    end
  endtask

  // Every accepted result is checked at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result(value, encoded_length, truncated);
  end

  // Receiver side: short random stalls, plus one long hold-off while the
  // sender keeps offering bytes, so that the result queue fills and the
  // input stalls.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        holding   = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding   = 1'b0;
        out_ready <= 1'b1;
      end else if (may_idle() && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed codes, random stream, drain.
  initial begin
    int guard;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Single-byte codes at both ends of the range.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // Largest values for two and three byte codes, then a four byte code.
    send_byte(8'hBF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hDF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hE5, 1'b0); send_byte(8'h12, 1'b0); send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    // Five-byte code: the header payload bits must be thrown away.
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    // Stream ends on the header of a longer code.
    send_byte(8'hC3, 1'b0 | 1'b1);
    // Stream ends partway into four and five byte codes.
    send_byte(8'hE0, 1'b0); send_byte(8'hAB, 1'b1);
    send_byte(8'hF8, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b1);
    // Stream ends exactly on the byte that completes a code.
    send_byte(8'h81, 1'b0); send_byte(8'h7E, 1'b1);
    // Stream ends on a single-byte code: nothing extra is due.
    send_byte(8'h55, 1'b1);

    // Mostly well-formed codes, with some loose bytes mixed in.
    byte_goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < byte_goal) begin
      if ($urandom_range(0, 6) == 0)
        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      else
        send_random_code();
    end
    in_valid <= 1'b0;

    guard = 0;
    while (tracker.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    tracker.final_check();
    if (tracker.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog that fails the run if the main sequence has not finished.
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/pvd_pkg.sv
rtl/pvd_step.sv
rtl/prefix_varint_decoder_top.sv
bench/prefix_varint_decoder_top_test.sv
